// ----- rtl/tva_pkg.sv -----
// Shared constants, codes and transaction types of the touch voice allocator.
`timescale 1ns / 1ps
package tva_pkg;

  localparam int VOICE_SLOTS = 16;
  localparam int IDX_W = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int DIV_CNT_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int STAMP_W = 64;
  localparam int PORT_W = 5;
  localparam int STEP_W = 10;
  localparam int BASE_W = 16;
  localparam int PROD_W = IDX_W + STEP_W;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_CONTACT_LIMIT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ASSIGN_MODE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_NODE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NODE_STEP = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PORT_COUNT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_LED_ENABLE = 3'd5;

  // Configuration reset values.
  localparam logic [4:0] RST_CONTACT_LIMIT = 5'd16;
  localparam logic RST_ASSIGN_MODE = 1'b0;
  localparam logic [BASE_W-1:0] RST_BASE_NODE = 16'd13000;
  localparam logic [STEP_W-1:0] RST_NODE_STEP = 10'd10;
  localparam logic [PORT_W-1:0] RST_PORT_COUNT = 5'd1;
  localparam logic RST_LED_ENABLE = 1'b1;

  // Item codes.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CONTACT = 1'b1;

  localparam logic [1:0] CS_INVALID = 2'd0;
  localparam logic [1:0] CS_START = 2'd1;
  localparam logic [1:0] CS_MOVE = 2'd2;
  localparam logic [1:0] CS_END = 2'd3;

  localparam logic [1:0] LED_NONE = 2'd0;
  localparam logic [1:0] LED_ON = 2'd1;
  localparam logic [1:0] LED_OFF = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] contact_id;
    logic [1:0] contact_state;
  } item_t;

  typedef struct packed {
    logic [3:0]  voice_num;
    logic [16:0] node_index;
    logic [3:0]  port_index;
    logic        gate;
    logic [1:0]  led_action;
  } result_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_voice;
  } map_req_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] voice;
  } map_rsp_t;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [STAMP_W-1:0] wr_data;
  } stamp_req_t;

  typedef struct packed {
    logic              start;
    logic [IDX_W-1:0]  dividend;
    logic [PORT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [IDX_W-1:0]  quotient;
    logic [PORT_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- rtl/tva_voice_map.sv -----
// Contact-to-voice map: synchronous memory with per-entry assigned flags.
`timescale 1ns / 1ps
module tva_voice_map (
  input  logic              clk,
  input  logic              rst,
  input  tva_pkg::map_req_t req,
  output tva_pkg::map_rsp_t rsp
);
  import tva_pkg::*;

  logic [IDX_W-1:0] mem [VOICE_SLOTS];
  logic [VOICE_SLOTS-1:0] assigned;
  logic [IDX_W-1:0] rd_voice;
  logic rd_assigned;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_voice;
    end
    if (req.rd_en) begin
      rd_voice <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      assigned <= '0;
      rd_assigned <= 1'b0;
    end else begin
      if (req.wr_en) begin
        assigned[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_assigned <= assigned[req.rd_addr];
      end
    end
  end

  assign rsp.valid = rd_assigned;
  assign rsp.voice = rd_voice;

endmodule

// ----- rtl/tva_stamp_store.sv -----
// Per-voice frame stamp memory; entries never written read as zero.
`timescale 1ns / 1ps
module tva_stamp_store (
  input  logic                        clk,
  input  logic                        rst,
  input  tva_pkg::stamp_req_t         req,
  output logic [tva_pkg::STAMP_W-1:0] rd_data
);
  import tva_pkg::*;

  logic [STAMP_W-1:0] mem [VOICE_SLOTS];
  logic [VOICE_SLOTS-1:0] written;
  logic [STAMP_W-1:0] rd_q;
  logic rd_written;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_written <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_written <= written[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_q : '0;

endmodule

// ----- rtl/tva_divider.sv -----
// Restoring divider, one quotient bit per cycle, for voice over port count.
`timescale 1ns / 1ps
module tva_divider (
  input  logic              clk,
  input  logic              rst,
  input  tva_pkg::div_req_t req,
  output tva_pkg::div_rsp_t rsp
);
  import tva_pkg::*;

  logic                 run;
  logic                 done;
  logic [DIV_CNT_W-1:0] count;
  logic [IDX_W-1:0]     dvd;
  logic [IDX_W-1:0]     quo;
  logic [PORT_W-1:0]    rem;
  logic [PORT_W-1:0]    dvs;
  logic [PORT_W:0]      trial;
  logic                 fits;

  assign trial = {rem, dvd[IDX_W-1]};
  assign fits = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      run <= 1'b1;
      done <= 1'b0;
    end else if (run && count == '0) begin
      run <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      quo <= '0;
      count <= DIV_CNT_W'(IDX_W - 1);
    end else if (run) begin
      // The remainder stays below the divisor, so it always fits back in PORT_W bits.
      rem <= fits ? PORT_W'(trial - {1'b0, dvs}) : PORT_W'(trial);
      quo <= IDX_W'({quo, fits});
      dvd <= IDX_W'({dvd, 1'b0});
      count <= count - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;
  assign rsp.remainder = rem;

endmodule

// ----- rtl/touch_voice_allocator_top.sv -----
// Touch voice allocator top level: command sequencer, configuration and result register.
// A direct start writes the voice map, then stamps, divides, multiplies and emits;
// a move or end first reads the map; an assign-mode start first scans the stamps.
// Frames and dropped contacts stay idle; an unstarted move or end stops after the map read.
// Throughput: one transaction at a time; a new one is taken in the cycle the result shows.
// Reset (rst, synchronous) restores the configuration defaults and clears all voice state.
`timescale 1ns / 1ps
module touch_voice_allocator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  tva_pkg::item_t                      item,
  output logic                                result_strobe,
  output tva_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [tva_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tva_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tva_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MAPRD = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_STAMP = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [4:0]        contact_limit;
  logic              assign_mode;
  logic [BASE_W-1:0] base_node;
  logic [STEP_W-1:0] node_step;
  logic [PORT_W-1:0] port_count;
  logic              led_enable;

  logic [STAMP_W-1:0] frame_count;
  logic               skip_rest;

  item_t              item_q;
  logic [IDX_W-1:0]   voice;
  logic [IDX_W-1:0]   cnt;
  logic [IDX_W-1:0]   best_idx;
  logic [STAMP_W-1:0] best_stamp;
  logic [IDX_W-1:0]   best_idx_next;
  logic [STAMP_W-1:0] best_stamp_next;
  logic [PROD_W-1:0]  prod;

  logic [CNT_W-1:0]   lim;
  logic [PORT_W-1:0]  ports;
  logic [IDX_W-1:0]   id_idx;
  logic               accept;
  logic               handled;
  logic               scan_last;

  map_req_t           map_req;
  map_rsp_t           map_rsp;
  stamp_req_t         stamp_req;
  logic [STAMP_W-1:0] stamp_rdata;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  result_t            result_next;

  tva_voice_map u_map (
    .clk (clk),
    .rst (rst),
    .req (map_req),
    .rsp (map_rsp)
  );

  tva_stamp_store u_stamp (
    .clk     (clk),
    .rst     (rst),
    .req     (stamp_req),
    .rd_data (stamp_rdata)
  );

  tva_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    if (32'(contact_limit) > 32'(VOICE_SLOTS)) begin
      lim = CNT_W'(VOICE_SLOTS);
    end else begin
      lim = CNT_W'(contact_limit);
    end
  end

  assign ports = (port_count == '0) ? PORT_W'(1) : port_count;
  assign id_idx = item.contact_id[IDX_W-1:0];
  assign accept = start && (state == S_IDLE);
  assign busy = (state != S_IDLE);

  // A contact that is processed: not skipped, in range and not invalid.
  assign handled = (item.opcode == OP_CONTACT) && !skip_rest &&
                   (32'(item.contact_id) < 32'(lim)) && (item.contact_state != CS_INVALID);

  assign scan_last = ({1'b0, cnt} == lim - 1'b1);

  always_comb begin
    if (cnt == '0 || stamp_rdata < best_stamp) begin
      best_idx_next = cnt;
      best_stamp_next = stamp_rdata;
    end else begin
      best_idx_next = best_idx;
      best_stamp_next = best_stamp;
    end
  end

  always_comb begin
    state_next = state;
    map_req = '0;
    stamp_req = '0;
    div_req.start = 1'b0;
    div_req.dividend = voice;
    div_req.divisor = ports;
    case (state)
      S_IDLE: begin
        if (accept && handled) begin
          if (item.contact_state == CS_START) begin
            if (assign_mode) begin
              stamp_req.rd_en = 1'b1;
              stamp_req.rd_addr = '0;
              state_next = S_SCAN;
            end else begin
              map_req.wr_en = 1'b1;
              map_req.wr_addr = id_idx;
              map_req.wr_voice = id_idx;
              state_next = S_STAMP;
            end
          end else begin
            map_req.rd_en = 1'b1;
            map_req.rd_addr = id_idx;
            state_next = S_MAPRD;
          end
        end
      end
      S_MAPRD: begin
        // A move or end for a contact that never started gives no result.
        state_next = map_rsp.valid ? S_STAMP : S_IDLE;
      end
      S_SCAN: begin
        if (scan_last) begin
          map_req.wr_en = 1'b1;
          map_req.wr_addr = item_q.contact_id[IDX_W-1:0];
          map_req.wr_voice = best_idx_next;
          state_next = S_STAMP;
        end else begin
          stamp_req.rd_en = 1'b1;
          stamp_req.rd_addr = cnt + 1'b1;
        end
      end
      S_STAMP: begin
        stamp_req.wr_en = 1'b1;
        stamp_req.wr_addr = voice;
        stamp_req.wr_data = frame_count;
        div_req.start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    result_next.voice_num = 4'(voice);
    result_next.node_index = 17'(32'(base_node) + 32'(prod));
    result_next.port_index = 4'(div_rsp.remainder);
    result_next.gate = item_q.contact_state inside {CS_START, CS_MOVE};
    if (led_enable && item_q.contact_state == CS_START) begin
      result_next.led_action = LED_ON;
    end else if (led_enable && item_q.contact_state == CS_END) begin
      result_next.led_action = LED_OFF;
    end else begin
      result_next.led_action = LED_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_strobe <= 1'b0;
      frame_count <= '0;
      skip_rest <= 1'b0;
      contact_limit <= RST_CONTACT_LIMIT;
      assign_mode <= RST_ASSIGN_MODE;
      base_node <= RST_BASE_NODE;
      node_step <= RST_NODE_STEP;
      port_count <= RST_PORT_COUNT;
      led_enable <= RST_LED_ENABLE;
    end else begin
      state <= state_next;
      result_strobe <= (state == S_EMIT);
      if (accept) begin
        if (item.opcode == OP_FRAME) begin
          frame_count <= frame_count + 1'b1;
          skip_rest <= 1'b0;
        end else if (32'(item.contact_id) >= 32'(lim)) begin
          skip_rest <= 1'b1;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CONTACT_LIMIT: contact_limit <= cfg_data[4:0];
          CFG_ASSIGN_MODE:   assign_mode <= cfg_data[0];
          CFG_BASE_NODE:     base_node <= cfg_data[BASE_W-1:0];
          CFG_NODE_STEP:     node_step <= cfg_data[STEP_W-1:0];
          CFG_PORT_COUNT:    port_count <= cfg_data[PORT_W-1:0];
          CFG_LED_ENABLE:    led_enable <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
      voice <= id_idx;
      cnt <= '0;
    end
    if (state == S_MAPRD) begin
      voice <= map_rsp.voice;
    end
    if (state == S_SCAN) begin
      cnt <= cnt + 1'b1;
      best_idx <= best_idx_next;
      best_stamp <= best_stamp_next;
      if (scan_last) begin
        voice <= best_idx_next;
      end
    end
    if (state == S_MUL) begin
      prod <= PROD_W'(div_rsp.quotient) * PROD_W'(node_step);
    end
    if (state == S_EMIT) begin
      result <= result_next;
    end
  end

endmodule

// ----- rtl/tva_checker.sv -----
// Port-level checker for the touch voice allocator, bound to the top level.
`timescale 1ns / 1ps
module tva_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_strobe,
  input tva_pkg::result_t result
);
  import tva_pkg::*;

  // A result closes its transaction, so the block is free again when it shows.
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> !busy)
    else $error("result strobe while busy");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result strobe without preceding work");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("two results in consecutive cycles");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_strobe)
    else $error("result in the cycle after a transaction was taken");

  a_led_on_gated: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.led_action == LED_ON) |-> result.gate)
    else $error("LED on request with gate low");

endmodule

bind touch_voice_allocator_top tva_checker u_tva_checker (.*);

// ----- dv/tb_touch_voice_allocator_top.sv -----
// Testbench of the touch voice allocator: directed and random contact traffic.
`timescale 1ns / 1ps
module tb_touch_voice_allocator_top;
  import tva_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_COUNT = 10;
  localparam int PHASE_ITEMS = 125;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic result_strobe;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the configuration.
  logic [4:0] limit_reg;
  logic mode_reg;
  logic [15:0] base_reg;
  logic [9:0] step_reg;
  logic [4:0] ports_reg;
  logic led_reg;

  // Predictor copy of the voice state.
  logic has_voice [VOICE_SLOTS];
  logic [IDX_W-1:0] voice_map [VOICE_SLOTS];
  logic [63:0] voice_stamp [VOICE_SLOTS];
  logic [63:0] frame_no;
  logic skipping;

  result_t expected_routes[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit live [VOICE_SLOTS];

  always #5 clk = ~clk;

  touch_voice_allocator_top i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_strobe(result_strobe),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("touch_voice_allocator_top test failed");
      $finish;
    end
  end

  task automatic note_error(input string msg);
    if (errors < 10) $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : check_routes
    result_t want;
    if (!rst && result_strobe === 1'b1) begin
      if (expected_routes.size() == 0) begin
        note_error($sformatf("result with nothing expected: voice %0d node %0d port %0d",
                             result.voice_num, result.node_index, result.port_index));
      end else begin
        want = expected_routes.pop_front();
        if (result.voice_num !== want.voice_num || result.node_index !== want.node_index ||
            result.port_index !== want.port_index || result.gate !== want.gate ||
            result.led_action !== want.led_action) begin
          note_error($sformatf({"expected voice %0d node %0d port %0d gate %0b led %0d, ",
                                "got voice %0d node %0d port %0d gate %0b led %0d"},
                               want.voice_num, want.node_index, want.port_index, want.gate,
                               want.led_action, result.voice_num, result.node_index,
                               result.port_index, result.gate, result.led_action));
        end
      end
    end
  end

  function automatic int active_limit();
    return (limit_reg > VOICE_SLOTS) ? VOICE_SLOTS : int'(limit_reg);
  endfunction

  // Works out the routing of one accepted transaction.
  task automatic route_contact(input item_t it);
    int lim;
    int best;
    int voice;
    int ports;
    int id;
    result_t r;
    lim = active_limit();
    id = int'(it.contact_id);
    if (it.opcode == OP_FRAME) begin
      frame_no = frame_no + 64'd1;
      skipping = 1'b0;
      return;
    end
    if (skipping) return;
    if (id >= lim) begin
      skipping = 1'b1;
      return;
    end
    if (it.contact_state == CS_INVALID) return;
    if (it.contact_state == CS_START) begin
      if (mode_reg) begin
        best = 0;
        for (int i = 1; i < lim; i++) begin
          if (voice_stamp[i] < voice_stamp[best]) best = i;
        end
        voice_map[id] = IDX_W'(best);
      end else begin
        voice_map[id] = it.contact_id[IDX_W-1:0];
      end
      has_voice[id] = 1'b1;
    end
    // A move or end of a contact that never started is dropped.
    if (!has_voice[id]) return;
    voice = int'(voice_map[id]);
    voice_stamp[voice] = frame_no;
    ports = (ports_reg == 5'd0) ? 1 : int'(ports_reg);
    r.voice_num = 4'(voice);
    r.node_index = 17'(int'(base_reg) + (voice / ports) * int'(step_reg));
    r.port_index = 4'(voice % ports);
    r.gate = (it.contact_state != CS_END);
    if (led_reg && it.contact_state == CS_START) r.led_action = LED_ON;
    else if (led_reg && it.contact_state == CS_END) r.led_action = LED_OFF;
    else r.led_action = LED_NONE;
    expected_routes.push_back(r);
  endtask

  // Called in the time step of a rising edge; leaves start high after the accept.
  task automatic issue_item(input item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    route_contact(it);
  endtask

  task automatic send(input logic op, input int id, input logic [1:0] st);
    item_t it;
    it.opcode = op;
    it.contact_id = 8'(id);
    it.contact_state = st;
    issue_item(it);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      CFG_CONTACT_LIMIT: limit_reg = 5'(value);
      CFG_ASSIGN_MODE: mode_reg = 1'(value);
      CFG_BASE_NODE: base_reg = 16'(value);
      CFG_NODE_STEP: step_reg = 10'(value);
      CFG_PORT_COUNT: ports_reg = 5'(value);
      CFG_LED_ENABLE: led_reg = 1'(value);
      default: ;
    endcase
  endtask

  task automatic set_config(input int limit, input int mode, input int base, input int step,
                            input int ports, input int led);
    write_reg(CFG_CONTACT_LIMIT, limit);
    write_reg(CFG_ASSIGN_MODE, mode);
    write_reg(CFG_BASE_NODE, base);
    write_reg(CFG_NODE_STEP, step);
    write_reg(CFG_PORT_COUNT, ports);
    write_reg(CFG_LED_ENABLE, led);
    cfg_we <= 1'b0;
  endtask

  // Reset configuration: direct assignment, one port, LEDs on.
  task automatic test_reset_defaults();
    send(OP_FRAME, 255, CS_END);
    send(OP_CONTACT, 0, CS_START);
    send(OP_CONTACT, 0, CS_MOVE);
    send(OP_CONTACT, 0, CS_END);
    send(OP_CONTACT, 5, CS_MOVE);
    send(OP_CONTACT, 6, CS_END);
    send(OP_CONTACT, 3, CS_INVALID);
    send(OP_CONTACT, 15, CS_START);
    // An id at the limit drops the rest of the frame.
    send(OP_CONTACT, 16, CS_MOVE);
    send(OP_CONTACT, 2, CS_START);
    send(OP_FRAME, 0, CS_INVALID);
    send(OP_CONTACT, 255, CS_INVALID);
    send(OP_FRAME, 170, CS_START);
    send(OP_CONTACT, 2, CS_START);
    // The voice stays with the contact after its end.
    send(OP_CONTACT, 0, CS_MOVE);
  endtask

  task automatic test_least_recent_extremes();
    settle();
    set_config(16, 1, 65535, 1023, 1, 0);
    send(OP_FRAME, 85, CS_MOVE);
    send(OP_CONTACT, 3, CS_START);
    send(OP_CONTACT, 4, CS_START);
    send(OP_CONTACT, 5, CS_START);
    send(OP_CONTACT, 3, CS_MOVE);
    send(OP_CONTACT, 4, CS_END);
    send(OP_FRAME, 0, CS_INVALID);
    send(OP_CONTACT, 7, CS_START);
  endtask

  task automatic test_zero_limit_and_ports();
    settle();
    set_config(0, 0, 0, 0, 0, 1);
    send(OP_CONTACT, 0, CS_START);
    send(OP_FRAME, 0, CS_INVALID);
    settle();
    // A limit above the build size is clamped; a port count of zero acts as one.
    set_config(31, 1, 500, 7, 0, 1);
    send(OP_CONTACT, 15, CS_START);
    send(OP_CONTACT, 15, CS_MOVE);
  endtask

  function automatic item_t make_item(input int lim);
    item_t it;
    int r;
    int id;
    r = $urandom_range(0, 99);
    it.opcode = OP_CONTACT;
    it.contact_id = 8'($urandom);
    it.contact_state = 2'($urandom);
    if (r < 12) begin
      it.opcode = OP_FRAME;
    end else if (r >= 16 && lim > 0) begin
      id = $urandom_range(0, lim - 1);
      it.contact_id = 8'(id);
      r = $urandom_range(0, 99);
      if (!live[id]) begin
        if (r < 85) it.contact_state = CS_START;
      end else if (r < 65) begin
        it.contact_state = CS_MOVE;
      end else if (r < 90) begin
        it.contact_state = CS_END;
      end
      if (it.contact_state == CS_START) live[id] = 1'b1;
      if (it.contact_state == CS_END) live[id] = 1'b0;
    end
    return it;
  endfunction

  function automatic int pick_extreme(input int lo, input int hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic test_random_traffic();
    int done;
    int limit;
    int ports;
    item_t it;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      limit = (phase % 3 == 0) ? pick_extreme(1, 31) : pick_extreme(1, 16);
      ports = ($urandom_range(0, 4) == 0) ? 0 : pick_extreme(1, 16);
      set_config(limit, $urandom_range(0, 1), pick_extreme(0, 65535),
                 pick_extreme(0, 1023), ports, $urandom_range(0, 1));
      no_idle = (phase % 4 == 3);
      done = 0;
      while (done < PHASE_ITEMS) begin
        it = make_item(active_limit());
        issue_item(it);
        done++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    limit_reg = RST_CONTACT_LIMIT;
    mode_reg = RST_ASSIGN_MODE;
    base_reg = RST_BASE_NODE;
    step_reg = RST_NODE_STEP;
    ports_reg = RST_PORT_COUNT;
    led_reg = RST_LED_ENABLE;
    for (int i = 0; i < VOICE_SLOTS; i++) begin
      has_voice[i] = 1'b0;
      voice_map[i] = '0;
      voice_stamp[i] = '0;
      live[i] = 1'b0;
    end
    frame_no = '0;
    skipping = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_least_recent_extremes();
    test_zero_limit_and_ports();
    test_random_traffic();
    settle();
    if (errors == 0 && expected_routes.size() == 0) begin
      $display("touch_voice_allocator_top test passed");
    end else begin
      $display("touch_voice_allocator_top test failed");
    end
    $finish;
  end

endmodule
